@@ rtl/rk4pp_pkg.sv @@
// Package for the RK4 particle push through Gaussian lenses.
// Holds fixed-point constants, the sequencer state type, the saturate and
// round helpers and the exp(-x) table built at elaboration. No dependencies.
package rk4pp_pkg;

  // Number format: signed Q16.16 in 32 bits
  localparam int FRAC_BITS = 16;
  localparam int EXP_SIZE  = 256;
  localparam int EXP_LOG2  = 8;
  localparam int G_W       = FRAC_BITS + 1;
  localparam int SUM_W     = 37;
  localparam int ACC_W     = 35;
  localparam int PROD_W    = 69;
  localparam int RND_W     = PROD_W - FRAC_BITS;

  // exp table index sits in bits [IDX_LO+EXP_LOG2-1:IDX_LO] of u*falloff
  localparam int IDX_LO    = 2 * FRAC_BITS + 4 - EXP_LOG2;
  localparam int FAR_BIT   = 2 * FRAC_BITS + 4;

  // Reciprocal of three for a 31-bit dividend, exact after >> 32
  localparam logic [30:0] RECIP3 = 31'd1431655766;

  localparam logic [63:0] Q32_ONE   = 64'h1_0000_0000;
  localparam logic [63:0] Q32_INV_E = 64'd1580030169;
  localparam int          EXP_TERMS = 24;

  // Register indexes of the configuration port
  localparam logic [2:0] REG_STEP     = 3'd0;
  localparam logic [2:0] REG_COUNT    = 3'd1;
  localparam logic [2:0] REG_SLOT     = 3'd2;
  localparam logic [2:0] REG_LENS_X   = 3'd3;
  localparam logic [2:0] REG_LENS_Y   = 3'd4;
  localparam logic [2:0] REG_LENS_Z   = 3'd5;
  localparam logic [2:0] REG_FALLOFF  = 3'd6;
  localparam logic [2:0] REG_STRENGTH = 3'd7;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RECIP,
    S_RECIP_W,
    S_LRD,
    S_LOFF,
    S_MSQ,
    S_MUL,
    S_MUH,
    S_GCALC,
    S_MGX,
    S_MGZ,
    S_MTX,
    S_MTZ,
    S_SUMZ,
    S_KSAT,
    S_ADV_M,
    S_ADV_W,
    S_FIN_M,
    S_FIN_W
  } state_t;

  typedef struct packed {
    logic               ovf;
    logic signed [31:0] val;
  } sat_t;

  typedef logic [EXP_SIZE-1:0][G_W-1:0] exp_tab_t;

  // Clamp to 32 bits signed, flag on clamp
  function automatic sat_t sat32(input logic signed [PROD_W-1:0] v);
    sat_t r;
    if (v > PROD_W'(64'sh7FFF_FFFF)) begin
      r.ovf = 1'b1;
      r.val = 32'sh7FFF_FFFF;
    end else if (v < -PROD_W'(64'sh8000_0000)) begin
      r.ovf = 1'b1;
      r.val = 32'sh8000_0000;
    end else begin
      r.ovf = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

  // Drop the fraction bits of a product, rounding half up
  function automatic logic signed [RND_W-1:0] rnd(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + PROD_W'(1 << (FRAC_BITS - 1));
    return t[PROD_W-1:FRAC_BITS];
  endfunction

  // exp(-16k/EXP_SIZE): Taylor series of the fraction in Q32, then e^-1 per unit
  function automatic exp_tab_t gen_exp_tab();
    exp_tab_t           tab;
    logic [63:0]        x;
    logic [63:0]        n;
    logic [63:0]        f;
    logic [63:0]        t;
    logic [63:0]        r;
    logic signed [65:0] s;
    for (int k = 0; k < EXP_SIZE; k++) begin
      x = 64'(k) << (36 - EXP_LOG2);
      n = x >> 32;
      f = x & 64'hFFFF_FFFF;
      t = Q32_ONE;
      s = $signed({2'b00, Q32_ONE});
      for (int i = 1; i <= EXP_TERMS; i++) begin
        t = ((t * f) >> 32) / 64'(i);
        if (i[0]) s = s - $signed({2'b00, t});
        else      s = s + $signed({2'b00, t});
      end
      if (s < 0) s = '0;
      r = s[63:0];
      for (logic [63:0] m = 0; m < n; m++) begin
        r = (r * Q32_INV_E) >> 32;
      end
      tab[k] = G_W'((r + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = gen_exp_tab();

endpackage

@@ rtl/rk4_particle_step_gaussian_lenses.sv @@
// Top level of the RK4 particle push through Gaussian lenses.
// Uses rk4pp_pkg for constants, helpers and the exp table.
// One shared multiplier run by a state machine; lens table in small memories.
//
// Usage:
//   Input channel in_* carries one particle word (position and velocity,
//   Q16.16). Output channel out_* returns the state after one RK4 step and
//   a saturation flag. Both use valid/ready.
//   Configuration: write cfg_wdata to register cfg_index while cfg_we is
//   high, only while the block is idle. Lens fields go to entry lens_slot.
//   An accepted word runs through four RK4 stages, each a pass over the
//   active lenses followed by the state update (the final write-back in the last).
//   Every product goes through the single 36x33 multiplier. One word is
//   worked on at a time; in_ready is high only when the sequencer is idle.
//   A finished word sits in the output register; the next word may be
//   taken and worked on meanwhile, and only its final write-back waits until
//   the receiver has taken the previous result.
//   Reset: synchronous, active low. Step size 655, no lenses active, the
//   lens table reads as zero. No clearing pass is needed.
module rk4_particle_step_gaussian_lenses
  import rk4pp_pkg::*;
#(
  parameter int MAX_LENSES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_vel_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_new_pos_x,
  output logic signed [31:0] out_new_pos_y,
  output logic signed [31:0] out_new_pos_z,
  output logic signed [31:0] out_new_vel_x,
  output logic signed [31:0] out_new_vel_y,
  output logic signed [31:0] out_new_vel_z,
  output logic               out_saturated,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int LIDX_W = (MAX_LENSES > 1) ? $clog2(MAX_LENSES) : 1;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [30:0] step_r;
  logic [3:0]  lens_count_r;
  logic [2:0]  lens_slot_r;

  // Lens table memories and per-entry valid bits
  logic signed [31:0] mem_x    [MAX_LENSES];
  logic signed [31:0] mem_y    [MAX_LENSES];
  logic signed [31:0] mem_z    [MAX_LENSES];
  logic [30:0]        mem_fall [MAX_LENSES];
  logic signed [31:0] mem_gain [MAX_LENSES];
  logic [MAX_LENSES-1:0] vld_x_r, vld_y_r, vld_z_r, vld_fall_r, vld_gain_r;
  logic signed [31:0] rd_x_r, rd_y_r, rd_z_r, rd_gain_r;
  logic [30:0]        rd_fall_r;
  logic rv_x_r, rv_y_r, rv_z_r, rv_fall_r, rv_gain_r;

  // Sequencer counters
  logic [3:0] lens_i_r;
  logic [2:0] j_r;
  logic [1:0] stage_r;

  // Datapath registers
  logic signed [31:0]       st_r  [6];
  logic signed [31:0]       cur_r [6];
  logic signed [31:0]       res_r [6];
  logic signed [ACC_W-1:0]  acc_r [6];
  logic [30:0]              half_r;
  logic [28:0]              sixth_r;
  logic signed [31:0]       dx_r, dz_r, gain_r, tx_r, tz_r, ax_r, az_r;
  logic [31:0]              ady_r;
  logic [30:0]              w_r;
  logic [15:0]              uhi_r;
  logic [62:0]              m1_r;
  logic                     far_r;
  logic [EXP_LOG2-1:0]      idx_r;
  logic [G_W-1:0]           g_r;
  logic signed [SUM_W-1:0]  sx_r, sz_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     sat_r, out_valid_r, out_sat_r;

  // Shared multiplier operands
  logic signed [35:0] mul_a;
  logic signed [32:0] mul_b;

  logic                    slot_ok;
  logic [LIDX_W-1:0]       waddr, raddr;
  logic signed [31:0]      cx, cy, cz, cgain;
  logic [30:0]             cfall;
  sat_t                    dx_s, dz_s, prod_s, ax_s, az_s, adv_s, fin_s;
  logic signed [32:0]      dy;
  logic [32:0]             ady_w;
  logic [67:0]             p_sum;
  logic signed [RND_W-1:0] prod_rnd;
  logic signed [31:0]      k_sel;
  logic [30:0]             weight;
  logic [31:0]             hp1, hp3;
  logic                    sat_evt;

  assign slot_ok = (32'(lens_slot_r) < MAX_LENSES);
  assign waddr   = LIDX_W'(lens_slot_r);
  assign raddr   = LIDX_W'(lens_i_r);
  assign hp1     = 32'(step_r) + 32'd1;
  assign hp3     = 32'(step_r) + 32'd3;

  // Configuration registers and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= 31'd655;
      lens_count_r <= '0;
      lens_slot_r  <= '0;
      vld_x_r      <= '0;
      vld_y_r      <= '0;
      vld_z_r      <= '0;
      vld_fall_r   <= '0;
      vld_gain_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP:  step_r <= cfg_wdata[30:0];
        REG_COUNT: begin
          lens_count_r <= (32'(cfg_wdata[3:0]) > MAX_LENSES) ? 4'(MAX_LENSES)
                                                            : cfg_wdata[3:0];
        end
        REG_SLOT:     lens_slot_r <= cfg_wdata[2:0];
        REG_LENS_X:   if (slot_ok) vld_x_r[waddr]    <= 1'b1;
        REG_LENS_Y:   if (slot_ok) vld_y_r[waddr]    <= 1'b1;
        REG_LENS_Z:   if (slot_ok) vld_z_r[waddr]    <= 1'b1;
        REG_FALLOFF:  if (slot_ok) vld_fall_r[waddr] <= 1'b1;
        REG_STRENGTH: if (slot_ok) vld_gain_r[waddr] <= 1'b1;
        default: ;
      endcase
    end
  end

  // Lens table: one write port from config, one registered read port
  always_ff @(posedge clk) begin
    if (cfg_we && slot_ok) begin
      if (cfg_index == REG_LENS_X)   mem_x[waddr]    <= cfg_wdata;
      if (cfg_index == REG_LENS_Y)   mem_y[waddr]    <= cfg_wdata;
      if (cfg_index == REG_LENS_Z)   mem_z[waddr]    <= cfg_wdata;
      if (cfg_index == REG_FALLOFF)  mem_fall[waddr] <= cfg_wdata[30:0];
      if (cfg_index == REG_STRENGTH) mem_gain[waddr] <= cfg_wdata;
    end
    rd_x_r    <= mem_x[raddr];
    rd_y_r    <= mem_y[raddr];
    rd_z_r    <= mem_z[raddr];
    rd_fall_r <= mem_fall[raddr];
    rd_gain_r <= mem_gain[raddr];
    rv_x_r    <= vld_x_r[raddr];
    rv_y_r    <= vld_y_r[raddr];
    rv_z_r    <= vld_z_r[raddr];
    rv_fall_r <= vld_fall_r[raddr];
    rv_gain_r <= vld_gain_r[raddr];
  end

  // Entries never written read as zero
  assign cx    = rv_x_r    ? rd_x_r    : '0;
  assign cy    = rv_y_r    ? rd_y_r    : '0;
  assign cz    = rv_z_r    ? rd_z_r    : '0;
  assign cfall = rv_fall_r ? rd_fall_r : '0;
  assign cgain = rv_gain_r ? rd_gain_r : '0;

  // Lens offsets
  assign dx_s  = sat32(PROD_W'(cur_r[0]) - PROD_W'(cx));
  assign dz_s  = sat32(PROD_W'(cur_r[2]) - PROD_W'(cz));
  assign dy    = 33'(cur_r[1]) - 33'(cy);
  assign ady_w = dy[32] ? 33'(-dy) : 33'(dy);

  // u*falloff rebuilt from its low and high partial products
  assign p_sum = 68'(m1_r) + (68'(prod_r[34:0]) << 32);

  assign prod_rnd = rnd(prod_r);
  assign prod_s   = sat32(PROD_W'(prod_rnd));
  assign ax_s     = sat32(PROD_W'(sx_r));
  assign az_s     = sat32(PROD_W'(sz_r));
  assign adv_s    = sat32(PROD_W'(st_r[j_r]) + PROD_W'(prod_s.val));
  assign fin_s    = adv_s;

  // Derivative component j: velocity, then acceleration (no axial part)
  always_comb begin
    case (j_r)
      3'd0:    k_sel = cur_r[3];
      3'd1:    k_sel = cur_r[4];
      3'd2:    k_sel = cur_r[5];
      3'd3:    k_sel = ax_r;
      3'd5:    k_sel = az_r;
      default: k_sel = '0;
    endcase
  end

  assign weight = (stage_r == 2'd2) ? step_r : half_r;

  // Saturation events of this cycle
  always_comb begin
    case (state_r)
      S_LOFF:           sat_evt = dx_s.ovf | dz_s.ovf;
      S_MGZ, S_MTX:     sat_evt = prod_s.ovf;
      S_KSAT:           sat_evt = ax_s.ovf | az_s.ovf;
      S_ADV_W, S_FIN_W: sat_evt = prod_s.ovf | adv_s.ovf;
      default:          sat_evt = 1'b0;
    endcase
  end

  // Next state and multiplier operands
  always_comb begin
    state_nxt = state_r;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_RECIP;
      S_RECIP: begin
        mul_a     = 36'(hp3[31:1]);
        mul_b     = 33'(RECIP3);
        state_nxt = S_RECIP_W;
      end
      S_RECIP_W: state_nxt = (lens_count_r != '0) ? S_LRD : S_KSAT;
      S_LRD:     state_nxt = S_LOFF;
      S_LOFF:    state_nxt = S_MSQ;
      S_MSQ: begin
        mul_a     = 36'(ady_r);
        mul_b     = 33'(ady_r);
        state_nxt = S_MUL;
      end
      S_MUL: begin
        mul_a     = 36'(prod_r[FRAC_BITS+31:FRAC_BITS]);
        mul_b     = 33'(w_r);
        state_nxt = S_MUH;
      end
      S_MUH: begin
        mul_a     = 36'(uhi_r[FAR_BIT-33:0]);
        mul_b     = 33'(w_r);
        state_nxt = S_GCALC;
      end
      S_GCALC:   state_nxt = S_MGX;
      S_MGX: begin
        mul_a     = 36'(gain_r);
        mul_b     = 33'(dx_r);
        state_nxt = S_MGZ;
      end
      S_MGZ: begin
        mul_a     = 36'(gain_r);
        mul_b     = 33'(dz_r);
        state_nxt = S_MTX;
      end
      S_MTX: begin
        mul_a     = 36'(tx_r);
        mul_b     = 33'(g_r);
        state_nxt = S_MTZ;
      end
      S_MTZ: begin
        mul_a     = 36'(tz_r);
        mul_b     = 33'(g_r);
        state_nxt = S_SUMZ;
      end
      S_SUMZ: begin
        state_nxt = ((5'(lens_i_r) + 5'd1) < 5'(lens_count_r)) ? S_LRD : S_KSAT;
      end
      S_KSAT:    state_nxt = (stage_r == 2'd3) ? S_FIN_M : S_ADV_M;
      S_ADV_M: begin
        mul_a     = 36'(k_sel);
        mul_b     = 33'(weight);
        state_nxt = S_ADV_W;
      end
      S_ADV_W: begin
        if (j_r == 3'd5) state_nxt = (lens_count_r != '0) ? S_LRD : S_KSAT;
        else             state_nxt = S_ADV_M;
      end
      S_FIN_M: begin
        mul_a = 36'(acc_r[j_r]);
        mul_b = 33'(sixth_r);
        if (!out_valid_r) state_nxt = S_FIN_W;
      end
      S_FIN_W:   state_nxt = (j_r == 3'd5) ? S_IDLE : S_FIN_M;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Counters, flags and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lens_i_r    <= '0;
      j_r         <= '0;
      stage_r     <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_sat_r   <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (sat_evt) sat_r <= 1'b1;
      case (state_r)
        S_IDLE:    if (in_valid) sat_r <= 1'b0;
        S_RECIP_W: begin
          lens_i_r <= '0;
          stage_r  <= '0;
        end
        S_SUMZ:    lens_i_r <= lens_i_r + 4'd1;
        S_KSAT:    j_r <= '0;
        S_ADV_W: begin
          if (j_r == 3'd5) begin
            j_r      <= '0;
            lens_i_r <= '0;
            stage_r  <= stage_r + 2'd1;
          end else begin
            j_r <= j_r + 3'd1;
          end
        end
        S_FIN_W: begin
          if (j_r == 3'd5) begin
            j_r         <= '0;
            out_valid_r <= 1'b1;
            out_sat_r   <= sat_r | sat_evt;
          end else begin
            j_r <= j_r + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Shared multiplier and datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          st_r[0]  <= in_pos_x;
          st_r[1]  <= in_pos_y;
          st_r[2]  <= in_pos_z;
          st_r[3]  <= in_vel_x;
          st_r[4]  <= in_vel_y;
          st_r[5]  <= in_vel_z;
          cur_r[0] <= in_pos_x;
          cur_r[1] <= in_pos_y;
          cur_r[2] <= in_pos_z;
          cur_r[3] <= in_vel_x;
          cur_r[4] <= in_vel_y;
          cur_r[5] <= in_vel_z;
          for (int i = 0; i < 6; i++) acc_r[i] <= '0;
          half_r <= hp1[31:1];
          sx_r   <= '0;
          sz_r   <= '0;
        end
      end
      S_RECIP_W: sixth_r <= prod_r[60:32];
      S_LOFF: begin
        dx_r   <= dx_s.val;
        dz_r   <= dz_s.val;
        ady_r  <= ady_w[31:0];
        w_r    <= cfall;
        gain_r <= cgain;
      end
      S_MUL: uhi_r <= prod_r[63:FRAC_BITS+32];
      S_MUH: m1_r  <= prod_r[62:0];
      S_GCALC: begin
        // g is zero once u*falloff reaches 16.0 in the argument
        far_r <= (|p_sum[67:FAR_BIT]) || ((|uhi_r[15:FAR_BIT-32]) && (w_r != '0));
        idx_r <= p_sum[IDX_LO+EXP_LOG2-1:IDX_LO];
      end
      S_MGX: g_r  <= far_r ? '0 : EXP_TAB[idx_r];
      S_MGZ: tx_r <= prod_s.val;
      S_MTX: tz_r <= prod_s.val;
      S_MTZ: sx_r <= sx_r - SUM_W'(prod_rnd);
      S_SUMZ: sz_r <= sz_r - SUM_W'(prod_rnd);
      S_KSAT: begin
        // k1 + 2 k2 + 2 k3 + k4, kept exact
        ax_r <= ax_s.val;
        az_r <= az_s.val;
        for (int i = 0; i < 3; i++) begin
          acc_r[i] <= acc_r[i] + ((stage_r == 2'd1 || stage_r == 2'd2)
                      ? (ACC_W'(cur_r[i+3]) <<< 1) : ACC_W'(cur_r[i+3]));
        end
        acc_r[3] <= acc_r[3] + ((stage_r == 2'd1 || stage_r == 2'd2)
                    ? (ACC_W'(ax_s.val) <<< 1) : ACC_W'(ax_s.val));
        acc_r[5] <= acc_r[5] + ((stage_r == 2'd1 || stage_r == 2'd2)
                    ? (ACC_W'(az_s.val) <<< 1) : ACC_W'(az_s.val));
      end
      S_ADV_W: begin
        cur_r[j_r] <= adv_s.val;
        if (j_r == 3'd5) begin
          sx_r <= '0;
          sz_r <= '0;
        end
      end
      S_FIN_W: res_r[j_r] <= fin_s.val;
      default: ;
    endcase
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_saturated = out_sat_r;
  assign out_new_pos_x = res_r[0];
  assign out_new_pos_y = res_r[1];
  assign out_new_pos_z = res_r[2];
  assign out_new_vel_x = res_r[3];
  assign out_new_vel_y = res_r[4];
  assign out_new_vel_z = res_r[5];

  // Checks on the sequencer
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_RECIP)
    else $error("accepted word did not start the sequence");

  a_lens_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOFF |-> lens_i_r < lens_count_r)
    else $error("lens index beyond active count");

  a_comp_range: assert property (@(posedge clk) disable iff (!rst_n)
    j_r <= 3'd5)
    else $error("component counter out of range");

  a_no_adv_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ADV_M |-> stage_r != 2'd3)
    else $error("state update issued in the last stage");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN_W |-> !out_valid_r)
    else $error("result written while previous word still pending");

endmodule
